// File: design/vmb_pkg.sv
// shared types, constants and helpers of the vu meter ballistics block
package vmb_pkg;

  // field and state widths
  localparam int SAMPLE_BITS = 24;
  localparam int GROUP_SIZE  = 4;
  localparam int GROUP_LOG2  = $clog2(GROUP_SIZE);
  localparam int PHASE_W     = GROUP_LOG2;
  localparam int STATE_FRAC  = 38;
  localparam int STAGE_W     = 42;
  localparam int DIFF_W      = 44;
  localparam int MAG_W       = DIFF_W - 1;
  localparam int SUM_W       = 47;
  localparam int WEIGHT_W    = 32;
  localparam int GAIN_W      = 16;
  localparam int LEVEL_W     = 25;
  localparam int CMD_W       = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 32;

  // serial multiplier sizing
  localparam int MPLIER_W    = WEIGHT_W;
  localparam int ACC_W       = MAG_W + 1;
  localparam int LEN_W       = $clog2(MPLIER_W + 1);
  localparam int TAIL_W      = GROUP_LOG2;

  // sample alignment and level rounding
  localparam int RECT_SHIFT  = STATE_FRAC + 1 - SAMPLE_BITS;
  localparam int RECT_W      = SAMPLE_BITS + RECT_SHIFT;
  localparam int LEVEL_SHIFT = 29 - GAIN_W;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(993212);
  localparam logic [GAIN_W-1:0]   GAIN_RESET   = GAIN_W'(38609);
  localparam logic [LEVEL_W-1:0]  LEVEL_MAX    = '1;

  localparam logic signed [STAGE_W-1:0] STAGE_MAX = {1'b0, {(STAGE_W-1){1'b1}}};
  localparam logic signed [STAGE_W-1:0] STAGE_MIN = {1'b1, {(STAGE_W-1){1'b0}}};

  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_READ   = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILTER_WEIGHT = 1'b0,
    CFG_OUTPUT_GAIN   = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_T1,
    ST_D1,
    ST_MAG1,
    ST_MUL1,
    ST_UPD1,
    ST_D2,
    ST_MAG2,
    ST_MUL2,
    ST_UPD2,
    ST_PEAK,
    ST_RLOAD,
    ST_RMUL,
    ST_LEVEL
  } state_t;

  // request to the serial multiplier
  typedef struct packed {
    logic                start;
    logic [LEN_W-1:0]    len;
    logic [MAG_W-1:0]    mcand;
    logic [MPLIER_W-1:0] mplier;
  } mul_req_t;

  // clamp a widened stage update to the signed stage range
  function automatic logic signed [STAGE_W-1:0] sat_stage(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(STAGE_MAX);
    lo = SUM_W'(STAGE_MIN);
    if (v > hi) begin
      sat_stage = STAGE_MAX;
    end else if (v < lo) begin
      sat_stage = STAGE_MIN;
    end else begin
      sat_stage = v[STAGE_W-1:0];
    end
  endfunction

endpackage

// File: design/vmb_serial_mul.sv
// bit-serial shift-add multiplier, one multiplier bit per cycle, lsb first
module vmb_serial_mul (
  input  logic                         clk,
  input  logic                         rst_n,
  input  vmb_pkg::mul_req_t            req_i,
  output logic                         busy_o,
  output logic [vmb_pkg::ACC_W-1:0]    acc_o,
  output logic [vmb_pkg::TAIL_W-1:0]   tail_o
);
  import vmb_pkg::*;

  logic                busy_r;
  logic [LEN_W-1:0]    cnt_r;
  logic [MAG_W-1:0]    mcand_r;
  logic [MPLIER_W-1:0] mplier_r;
  logic [ACC_W-1:0]    acc_r;
  logic [TAIL_W-1:0]   tail_r;
  logic [ACC_W:0]      sum;

  // partial sum for the current multiplier bit
  assign sum = {1'b0, acc_r} + (mplier_r[0] ? (ACC_W+1)'(mcand_r) : '0);

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req_i.start) begin
      busy_r <= 1'b1;
      cnt_r  <= req_i.len;
    end else if (busy_r) begin
      cnt_r <= cnt_r - LEN_W'(1);
      if (cnt_r == LEN_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // accumulator shifts right, dropped bits keep the last few in the tail
  always_ff @(posedge clk) begin
    if (req_i.start) begin
      mcand_r  <= req_i.mcand;
      mplier_r <= req_i.mplier;
      acc_r    <= '0;
      tail_r   <= '0;
    end else if (busy_r) begin
      mplier_r <= mplier_r >> 1;
      acc_r    <= sum[ACC_W:1];
      tail_r   <= {sum[0], tail_r[TAIL_W-1:1]};
    end
  end

  assign busy_o = busy_r;
  assign acc_o  = acc_r;
  assign tail_o = tail_r;

endmodule

// File: design/vu_meter_ballistics_top.sv
// vu meter ballistic filter: two-stage lowpass with held peak and gain on read
//
// One item is processed at a time. An audio sample runs through the first
// stage update (difference, magnitude, serial multiply, update) before the
// next item can be taken; every fourth sample also updates the second stage
// and the held peak. A read forms the level from the held peak and waits
// while the previous level still sits at the output; a clear is done in the
// idle state itself. The bit-serial multiplier steps through the weight bits:
// 32 for each filter stage, 16 for the output gain. The level sits in an
// output register, so samples keep flowing while it waits to be taken.
// Configuration writes are taken at any time and should be made while idle.
module vu_meter_ballistics_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [vmb_pkg::CMD_W-1:0]            in_command,
  input  logic signed [vmb_pkg::SAMPLE_BITS-1:0] in_sample,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [vmb_pkg::LEVEL_W-1:0]          out_level,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [vmb_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [vmb_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import vmb_pkg::*;

  state_t state_r, state_nxt;

  logic [WEIGHT_W-1:0]       weight_r;
  logic [GAIN_W-1:0]         gain_r;
  logic signed [STAGE_W-1:0] first_r;
  logic signed [STAGE_W-1:0] second_r;
  logic [STAGE_W-1:0]        peak_r;
  logic                      restart_r;
  logic [PHASE_W-1:0]        phase_r;
  logic                      out_valid_r;
  logic [LEVEL_W-1:0]        level_r;

  logic [SAMPLE_BITS-1:0]    mag_r;
  logic signed [DIFF_W-1:0]  t1_r;
  logic signed [DIFF_W-1:0]  d_r;
  logic                      neg_r;

  logic                      accept;
  cmd_t                      cmd;
  logic [SAMPLE_BITS-1:0]    in_mag;
  logic                      out_free;
  logic                      group_end;

  logic signed [DIFF_W-1:0]  rect_ext;
  logic signed [DIFF_W-1:0]  half_ext;
  logic signed [DIFF_W-1:0]  half_fix;
  logic [MAG_W-1:0]          d_abs;

  logic signed [SUM_W-1:0]   p1_ext;
  logic signed [SUM_W-1:0]   p2_ext;
  logic signed [SUM_W-1:0]   first_sum;
  logic signed [SUM_W-1:0]   second_sum;
  logic [STAGE_W-1:0]        peak_base;
  logic                      peak_take;
  logic [ACC_W:0]            lvl_sum;
  logic [ACC_W-LEVEL_SHIFT:0] lvl_full;
  logic [LEVEL_W-1:0]        lvl_sat;

  mul_req_t                  mul_req;
  logic                      mul_busy;
  logic [ACC_W-1:0]          mul_acc;
  logic [TAIL_W-1:0]         mul_tail;

  vmb_serial_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .req_i  (mul_req),
    .busy_o (mul_busy),
    .acc_o  (mul_acc),
    .tail_o (mul_tail)
  );

  assign accept    = in_valid && in_ready;
  assign cmd       = cmd_t'(in_command);
  assign out_free  = !out_valid_r || out_ready;
  assign group_end = (phase_r == PHASE_W'(GROUP_SIZE - 1));
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_level = level_r;

  // rectified sample magnitude
  assign in_mag = in_sample[SAMPLE_BITS-1] ? (~in_sample + SAMPLE_BITS'(1)) : in_sample;

  // sample minus half the second stage, halving rounds toward zero
  assign rect_ext = signed'(DIFF_W'({mag_r, {RECT_SHIFT{1'b0}}}));
  assign half_ext = DIFF_W'(second_r >>> 1);
  assign half_fix = signed'(DIFF_W'(second_r[STAGE_W-1] & second_r[0]));

  // magnitude of the difference fed to the multiplier
  assign d_abs = d_r[DIFF_W-1] ? MAG_W'(-d_r) : MAG_W'(d_r);

  // stage updates from the weighted product
  assign p1_ext     = signed'(SUM_W'(mul_acc));
  assign p2_ext     = signed'(SUM_W'({mul_acc, mul_tail}));
  assign first_sum  = neg_r ? (SUM_W'(first_r) - p1_ext) : (SUM_W'(first_r) + p1_ext);
  assign second_sum = neg_r ? (SUM_W'(second_r) - p2_ext) : (SUM_W'(second_r) + p2_ext);

  // peak hold
  assign peak_base = restart_r ? '0 : peak_r;
  assign peak_take = !second_r[STAGE_W-1] && (STAGE_W'(second_r) > peak_base);

  // level rounding and saturation
  assign lvl_sum  = {1'b0, mul_acc} + (ACC_W+1)'(1 << (LEVEL_SHIFT - 1));
  assign lvl_full = lvl_sum[ACC_W:LEVEL_SHIFT];
  assign lvl_sat  = (lvl_full > (ACC_W-LEVEL_SHIFT+1)'(LEVEL_MAX)) ? LEVEL_MAX
                                                                  : LEVEL_W'(lvl_full);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (cmd)
            CMD_SAMPLE: state_nxt = ST_T1;
            CMD_READ:   state_nxt = ST_RLOAD;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_T1:    state_nxt = ST_D1;
      ST_D1:    state_nxt = ST_MAG1;
      ST_MAG1:  state_nxt = ST_MUL1;
      ST_MUL1:  state_nxt = mul_busy ? ST_MUL1 : ST_UPD1;
      ST_UPD1:  state_nxt = group_end ? ST_D2 : ST_IDLE;
      ST_D2:    state_nxt = ST_MAG2;
      ST_MAG2:  state_nxt = ST_MUL2;
      ST_MUL2:  state_nxt = mul_busy ? ST_MUL2 : ST_UPD2;
      ST_UPD2:  state_nxt = ST_PEAK;
      ST_PEAK:  state_nxt = ST_IDLE;
      ST_RLOAD: state_nxt = ST_RMUL;
      ST_RMUL:  state_nxt = mul_busy ? ST_RMUL : ST_LEVEL;
      ST_LEVEL: state_nxt = out_free ? ST_IDLE : ST_LEVEL;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // state machine outputs
  always_comb begin
    in_ready       = 1'b0;
    mul_req.start  = 1'b0;
    mul_req.len    = LEN_W'(WEIGHT_W);
    mul_req.mcand  = d_abs;
    mul_req.mplier = weight_r;
    unique case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_MAG1, ST_MAG2: mul_req.start = 1'b1;
      ST_RLOAD: begin
        mul_req.start  = 1'b1;
        mul_req.len    = LEN_W'(GAIN_W);
        mul_req.mcand  = MAG_W'(peak_r);
        mul_req.mplier = MPLIER_W'(gain_r);
      end
      default: ;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= WEIGHT_RESET;
      gain_r   <= GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FILTER_WEIGHT: weight_r <= cfg_data[WEIGHT_W-1:0];
        CFG_OUTPUT_GAIN:   gain_r   <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // filter state, peak hold and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r     <= '0;
      second_r    <= '0;
      peak_r      <= '0;
      restart_r   <= 1'b1;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // a taken level empties the register unless a new level replaces it
      if (out_valid_r && out_ready && (state_r != ST_LEVEL)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept && (cmd == CMD_CLEAR)) begin
            first_r   <= '0;
            second_r  <= '0;
            peak_r    <= '0;
            restart_r <= 1'b1;
            phase_r   <= '0;
          end
        end
        ST_UPD1: begin
          first_r <= sat_stage(first_sum);
          phase_r <= group_end ? '0 : (phase_r + PHASE_W'(1));
        end
        ST_UPD2: second_r <= sat_stage(second_sum);
        ST_PEAK: begin
          peak_r    <= peak_take ? STAGE_W'(second_r) : peak_base;
          restart_r <= 1'b0;
        end
        ST_LEVEL: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            restart_r   <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // working values, no reset needed
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE:  mag_r   <= in_mag;
      ST_T1:    t1_r    <= rect_ext - half_ext - half_fix;
      ST_D1:    d_r     <= t1_r - DIFF_W'(first_r);
      ST_D2:    d_r     <= DIFF_W'(first_r) - DIFF_W'(second_r);
      ST_MAG1, ST_MAG2: neg_r <= d_r[DIFF_W-1];
      ST_LEVEL: begin
        if (out_free) begin
          level_r <= lvl_sat;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: design/vmb_checker.sv
// port-level checks for the vu meter ballistics block, bound to the top level
module vmb_checker (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic                                   in_valid,
  input logic                                   in_ready,
  input logic [vmb_pkg::CMD_W-1:0]              in_command,
  input logic                                   out_valid,
  input logic                                   out_ready,
  input logic [vmb_pkg::LEVEL_W-1:0]            out_level
);
  import vmb_pkg::*;

  logic in_xfer;
  assign in_xfer = in_valid && in_ready;

  // a stalled level stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_level))
    else $error("level changed or dropped while stalled");

  // a sample keeps the block busy for the filter update
  a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && (cmd_t'(in_command) == CMD_SAMPLE) |=> !in_ready)
    else $error("input taken again straight after a sample");

  // a read keeps the block busy while the level is formed
  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && (cmd_t'(in_command) == CMD_READ) |=> !in_ready)
    else $error("input taken again straight after a read");

  // the block is ready again in the cycle after a clear
  a_clear_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && (cmd_t'(in_command) == CMD_CLEAR) |=> in_ready)
    else $error("block not ready after a clear");

  // reset empties the output register
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("level valid after reset");

endmodule

bind vu_meter_ballistics_top vmb_checker u_vmb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .in_command (in_command),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_level  (out_level)
);
